// File: hdl/cma_pkg.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator package
// Shared sizes, op codes, register indexes and counter helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

   localparam int MAX_CLASSES = 16;
   localparam int COUNT_BITS  = 32;

   localparam int CLS_BITS  = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
   localparam int MAT_BITS  = 2 * CLS_BITS;
   localparam int MAT_DEPTH = 1 << MAT_BITS;
   localparam int NC_W      = ($clog2(MAX_CLASSES + 1) > 5) ? $clog2(MAX_CLASSES + 1) : 5;

   localparam int SCORE_BITS = 16;
   localparam int POS_BITS   = 5;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;
   localparam int OUT_BITS   = 32;

   typedef enum logic [1:0] {
      OP_SCORE = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   localparam logic REG_BINARY_MODE = 1'b0;
   localparam logic REG_NUM_CLASSES = 1'b1;

   typedef struct packed {
      logic                en;
      logic [CLS_BITS-1:0] pred;
      logic [CLS_BITS-1:0] tru;
   } count_req_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      logic [COUNT_BITS-1:0] r;
      r = (c == '1) ? c : c + COUNT_BITS'(1);
      return r;
   endfunction

   function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] c);
      logic [63:0] w;
      w = 64'(c);
      return w[OUT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/cma_channels.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator channels
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface cma_req_if import cma_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            op;
   logic [SCORE_BITS-1:0] out_score;
   logic [SCORE_BITS-1:0] target_score;
   logic                  last;
   logic [3:0]            query_row;
   logic [3:0]            query_col;

   modport source (output valid, op, out_score, target_score, last, query_row, query_col,
                   input ready);
   modport sink   (input valid, op, out_score, target_score, last, query_row, query_col,
                   output ready);
endinterface

interface cma_rsp_if import cma_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] cell_count;
   logic [OUT_BITS-1:0] class_instances;
   logic [OUT_BITS-1:0] class_errors;
   logic [OUT_BITS-1:0] total_errors;

   modport source (output valid, cell_count, class_instances, class_errors, total_errors,
                   input ready);
   modport sink   (input valid, cell_count, class_instances, class_errors, total_errors,
                   output ready);
endinterface

`default_nettype wire

// File: hdl/confusion_matrix_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator unit
// Streams score elements into a saturating confusion matrix and answers
// cell, per-class and total error queries.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake         | carries
//   ---------+-----------+-------------------+-----------------------------------
//   req_if   | in        | valid/ready       | op, scores, last, query row/col
//   rsp_if   | out       | valid/ready       | cell, instances, errors, total
//   APB      | in        | psel/penable      | binary_mode, num_classes
//
// One item per cycle while no query answer waits. An item sits in the input
// stage, where the class tracker and column counters update and the cell
// memory is read; a query answer is then registered into the result stage.
// The cell increment finishes in the result stage; a write-first bypass on the
// memory read keeps back-to-back hits on one cell exact.
// Synchronous reset clears control state and all cell valid bits at once, so
// the block takes items as soon as reset is released.
// A query waiting in the result stage stalls both stages; the input stage
// still takes one item while it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module confusion_matrix_accumulator_unit import cma_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   cma_req_if.sink          req_if,
   cma_rsp_if.source        rsp_if,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // configuration registers
   logic       binary_mode_ff;
   logic [4:0] num_classes_ff;

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_op_ff;
   logic [SCORE_BITS-1:0] s1_out_score_ff;
   logic [SCORE_BITS-1:0] s1_target_score_ff;
   logic                  s1_last_ff;
   logic [3:0]            s1_row_ff;
   logic [3:0]            s1_col_ff;

   // result stage: holds a pending query answer
   logic s2_valid_ff, s2_valid_in;

   logic          advance;
   logic          accept;
   logic          step;
   logic          clear;
   count_req_type count_req;

   assign pready = 1'b1;

   // APB: write on the access phase, read back the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         binary_mode_ff <= 1'b0;
         num_classes_ff <= 5'd2;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == REG_NUM_CLASSES) begin
            num_classes_ff <= pwdata[4:0];
         end else begin
            binary_mode_ff <= pwdata[0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_BINARY_MODE) begin
         prdata = 32'(binary_mode_ff);
      end else begin
         prdata = 32'(num_classes_ff);
      end
   end

   // hold everything while a query answer waits for the sink
   always_comb begin
      advance      = !(s2_valid_ff && !rsp_if.ready);
      req_if.ready = advance || !s1_valid_ff;
      accept       = req_if.valid && req_if.ready;
      step         = s1_valid_ff && advance && (s1_op_ff == OP_SCORE);
      clear        = s1_valid_ff && advance && (s1_op_ff == OP_CLEAR);

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      // only queries produce a result; drop the rest after the input stage
      if (advance) begin
         s2_valid_in = s1_valid_ff && (s1_op_ff == OP_QUERY);
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff           <= req_if.op;
         s1_out_score_ff    <= req_if.out_score;
         s1_target_score_ff <= req_if.target_score;
         s1_last_ff         <= req_if.last;
         s1_row_ff          <= req_if.query_row;
         s1_col_ff          <= req_if.query_col;
      end
   end

   cma_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .binary_mode  (binary_mode_ff),
      .num_classes  (num_classes_ff),
      .out_score    (s1_out_score_ff),
      .target_score (s1_target_score_ff),
      .last         (s1_last_ff),
      .count_req    (count_req)
   );

   cma_store u_store (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .clear           (clear),
      .count_req       (count_req),
      .query_row       (s1_row_ff),
      .query_col       (s1_col_ff),
      .cell_count      (rsp_if.cell_count),
      .class_instances (rsp_if.class_instances),
      .class_errors    (rsp_if.class_errors),
      .total_errors    (rsp_if.total_errors)
   );

   assign rsp_if.valid = s2_valid_ff;

endmodule

`default_nettype wire

// File: hdl/cma_tracker.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator class tracker
// Thresholds binary elements and tracks first-maximum argmaxes per vector.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_tracker import cma_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  binary_mode,
   input  wire logic [4:0]            num_classes,
   input  wire logic [SCORE_BITS-1:0] out_score,
   input  wire logic [SCORE_BITS-1:0] target_score,
   input  wire logic                  last,
   output count_req_type              count_req
);

   logic [CLS_BITS-1:0]   pred_idx_ff, pred_idx_in;
   logic [SCORE_BITS-1:0] pred_val_ff, pred_val_in;
   logic [CLS_BITS-1:0]   true_idx_ff, true_idx_in;
   logic [SCORE_BITS-1:0] true_val_ff, true_val_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;

   logic [NC_W-1:0] n_ext;
   logic [NC_W-1:0] n_use;
   logic            in_range;
   logic            take_pred;
   logic            take_true;
   logic            first;

   always_comb begin
      n_ext = NC_W'(num_classes);
      if (n_ext < NC_W'(2)) begin
         n_use = NC_W'(2);
      end else if (n_ext > NC_W'(MAX_CLASSES)) begin
         n_use = NC_W'(MAX_CLASSES);
      end else begin
         n_use = n_ext;
      end

      first     = (pos_ff == '0);
      in_range  = NC_W'(pos_ff) < n_use;
      take_pred = in_range && (first || out_score > pred_val_ff);
      take_true = in_range && (first || target_score > true_val_ff);

      pred_idx_in = take_pred ? CLS_BITS'(pos_ff) : pred_idx_ff;
      pred_val_in = take_pred ? out_score : pred_val_ff;
      true_idx_in = take_true ? CLS_BITS'(pos_ff) : true_idx_ff;
      true_val_in = take_true ? target_score : true_val_ff;

      // close the vector on last, otherwise advance and hold at the top
      if (last) begin
         pos_in = '0;
      end else if (pos_ff < POS_MAX) begin
         pos_in = pos_ff + POS_BITS'(1);
      end else begin
         pos_in = pos_ff;
      end

      count_req.en = step && (binary_mode || last);
      if (binary_mode) begin
         count_req.pred = CLS_BITS'(out_score[SCORE_BITS-1]);
         count_req.tru  = CLS_BITS'(target_score[SCORE_BITS-1]);
      end else begin
         count_req.pred = pred_idx_in;
         count_req.tru  = true_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_idx_ff <= '0;
         pred_val_ff <= '0;
         true_idx_ff <= '0;
         true_val_ff <= '0;
         pos_ff      <= '0;
      end else if (step && !binary_mode) begin
         pred_idx_ff <= pred_idx_in;
         pred_val_ff <= pred_val_in;
         true_idx_ff <= true_idx_in;
         true_val_ff <= true_val_in;
         pos_ff      <= pos_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/cma_store.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator counter store
// Cell memory with read-modify-write, column and total error counters.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_store import cma_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          clear,
   input  count_req_type      count_req,
   input  wire logic [3:0]    query_row,
   input  wire logic [3:0]    query_col,
   output logic [OUT_BITS-1:0] cell_count,
   output logic [OUT_BITS-1:0] class_instances,
   output logic [OUT_BITS-1:0] class_errors,
   output logic [OUT_BITS-1:0] total_errors
);

   logic [COUNT_BITS-1:0] mem [MAT_DEPTH];
   logic [MAT_DEPTH-1:0]  valid_ff;

   logic [COUNT_BITS-1:0] col_tot_ff [MAX_CLASSES];
   logic [COUNT_BITS-1:0] col_err_ff [MAX_CLASSES];
   logic [COUNT_BITS-1:0] err_total_ff;

   logic [COUNT_BITS-1:0] rd_ff;
   logic                  rd_valid_ff;
   logic                  wr_pend_ff;
   logic [MAT_BITS-1:0]   wr_addr_ff;

   logic [COUNT_BITS-1:0] q_tot_ff;
   logic [COUNT_BITS-1:0] q_err_ff;
   logic [COUNT_BITS-1:0] q_etot_ff;
   logic                  q_cell_ok_ff;
   logic                  q_col_ok_ff;

   logic [MAT_BITS-1:0]   raddr;
   logic [COUNT_BITS-1:0] wdata;
   logic                  bypass;
   logic [CLS_BITS-1:0]   qcol;
   logic                  row_ok;
   logic                  col_ok;

   always_comb begin
      qcol   = CLS_BITS'(query_col);
      row_ok = 32'(query_row) < MAX_CLASSES;
      col_ok = 32'(query_col) < MAX_CLASSES;
      if (count_req.en) begin
         raddr = {count_req.pred, count_req.tru};
      end else begin
         raddr = {CLS_BITS'(query_row), qcol};
      end
      wdata  = sat_inc(rd_valid_ff ? rd_ff : '0);
      bypass = wr_pend_ff && (wr_addr_ff == raddr);
   end

   // cell memory: write the incremented cell, read with write-first bypass
   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         mem[wr_addr_ff] <= wdata;
      end
      if (advance) begin
         rd_ff <= bypass ? wdata : mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_pend_ff) begin
         valid_ff[wr_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         wr_pend_ff <= advance && count_req.en;
         if (advance) begin
            rd_valid_ff <= bypass || valid_ff[raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wr_addr_ff <= raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < MAX_CLASSES; i++) begin
            col_tot_ff[i] <= '0;
            col_err_ff[i] <= '0;
         end
         err_total_ff <= '0;
      end else if (count_req.en) begin
         col_tot_ff[count_req.tru] <= sat_inc(col_tot_ff[count_req.tru]);
         if (count_req.pred != count_req.tru) begin
            col_err_ff[count_req.tru] <= sat_inc(col_err_ff[count_req.tru]);
            err_total_ff              <= sat_inc(err_total_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_tot_ff     <= col_tot_ff[qcol];
         q_err_ff     <= col_err_ff[qcol];
         q_etot_ff    <= err_total_ff;
         q_cell_ok_ff <= row_ok && col_ok;
         q_col_ok_ff  <= col_ok;
      end
   end

   always_comb begin
      cell_count      = to_out((q_cell_ok_ff && rd_valid_ff) ? rd_ff : '0);
      class_instances = to_out(q_col_ok_ff ? q_tot_ff : '0);
      class_errors    = to_out(q_col_ok_ff ? q_err_ff : '0);
      total_errors    = to_out(q_etot_ff);
   end

endmodule

`default_nettype wire

// File: bench/cma_matrix_checker.sv
// ----------------------------------------------------------------------------
// Confusion matrix checker
// Watches the request, result and register ports of the accumulator, keeps
// its own copy of the matrix counters and class tracker, and compares every
// query answer and register read against that copy.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_matrix_checker import cma_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   cma_req_if               req_mon,
   cma_rsp_if               rsp_mon,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic        pready,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic [31:0] prdata,
   output int               failures,
   output int               answers_due,
   output int               answers_checked,
   output int               vectors_closed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [SCORE_BITS-1:0] HALF_SCORE = 16'h8000;
   localparam int REPORT_LIMIT = 30;

   typedef struct packed {
      logic [OUT_BITS-1:0] cell_value;
      logic [OUT_BITS-1:0] instances;
      logic [OUT_BITS-1:0] errors;
      logic [OUT_BITS-1:0] total;
   } answer_type;

   logic [COUNT_BITS-1:0] cell_tally [MAX_CLASSES][MAX_CLASSES];
   logic [COUNT_BITS-1:0] true_tally [MAX_CLASSES];
   logic [COUNT_BITS-1:0] miss_tally [MAX_CLASSES];
   logic [COUNT_BITS-1:0] miss_total;

   logic [CLS_BITS-1:0]   lead_pred_idx;
   logic [CLS_BITS-1:0]   lead_true_idx;
   logic [SCORE_BITS-1:0] lead_pred_score;
   logic [SCORE_BITS-1:0] lead_true_score;
   logic [POS_BITS-1:0]   position;

   logic                  mode_binary;
   logic [4:0]            class_reg;

   answer_type            queued_answers [$];
   int                    fail_count    = 0;
   int                    checked_count = 0;
   int                    closed_count  = 0;

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   task automatic clear_tallies();
      for (int p = 0; p < MAX_CLASSES; p++) begin
         true_tally[p] = '0;
         miss_tally[p] = '0;
         for (int t = 0; t < MAX_CLASSES; t++) cell_tally[p][t] = '0;
      end
      miss_total = '0;
   endtask

   task automatic tally(input logic [CLS_BITS-1:0] pred, input logic [CLS_BITS-1:0] tru);
      cell_tally[pred][tru] = bump(cell_tally[pred][tru]);
      true_tally[tru] = bump(true_tally[tru]);
      if (pred != tru) begin
         miss_tally[tru] = bump(miss_tally[tru]);
         miss_total = bump(miss_total);
      end
   endtask

   // Advance the argmax tracker by one element; close the vector on last.
   task automatic take_element(input logic [SCORE_BITS-1:0] os,
                               input logic [SCORE_BITS-1:0] ts,
                               input logic                  closes);
      int classes;
      classes = (class_reg < 2) ? 2 : (class_reg > MAX_CLASSES) ? MAX_CLASSES : class_reg;
      if (mode_binary) begin
         tally(CLS_BITS'(os >= HALF_SCORE), CLS_BITS'(ts >= HALF_SCORE));
      end else begin
         if (position < classes) begin
            // strictly greater only, so the first maximum holds on ties
            if (position == 0 || os > lead_pred_score) begin
               lead_pred_score = os;
               lead_pred_idx   = CLS_BITS'(position);
            end
            if (position == 0 || ts > lead_true_score) begin
               lead_true_score = ts;
               lead_true_idx   = CLS_BITS'(position);
            end
         end
         if (closes) begin
            tally(lead_pred_idx, lead_true_idx);
            position = '0;
            closed_count++;
         end else if (position != POS_MAX) begin
            position = position + 1'b1;
         end
      end
   endtask

   task automatic check_value(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         clear_tallies();
         lead_pred_idx   = '0;
         lead_true_idx   = '0;
         lead_pred_score = '0;
         lead_true_score = '0;
         position        = '0;
         mode_binary     = 1'b0;
         class_reg       = 5'd2;
         queued_answers.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == REG_NUM_CLASSES) class_reg = pwdata[4:0];
               else mode_binary = pwdata[0];
            end else begin
               check_value("register read",
                           (paddr[2] == REG_NUM_CLASSES) ? 32'(class_reg) : 32'(mode_binary),
                           prdata);
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (queued_answers.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: answer with no query waiting, cell %0d total %0d",
                           $time, rsp_mon.cell_count, rsp_mon.total_errors);
            end else begin
               want = queued_answers.pop_front();
               check_value("cell_count", want.cell_value, rsp_mon.cell_count);
               check_value("class_instances", want.instances, rsp_mon.class_instances);
               check_value("class_errors", want.errors, rsp_mon.class_errors);
               check_value("total_errors", want.total, rsp_mon.total_errors);
               checked_count++;
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.op)
               OP_SCORE: begin
                  take_element(req_mon.out_score, req_mon.target_score, req_mon.last);
               end
               OP_QUERY: begin
                  want.cell_value = OUT_BITS'(cell_tally[req_mon.query_row][req_mon.query_col]);
                  want.instances  = OUT_BITS'(true_tally[req_mon.query_col]);
                  want.errors     = OUT_BITS'(miss_tally[req_mon.query_col]);
                  want.total      = OUT_BITS'(miss_total);
                  queued_answers.push_back(want);
               end
               OP_CLEAR: begin
                  // counters only: the tracker keeps its partial vector
                  clear_tallies();
               end
               default: ;
            endcase
         end
      end
      failures        <= fail_count;
      answers_due     <= queued_answers.size();
      answers_checked <= checked_count;
      vectors_closed  <= closed_count;
   end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Confusion matrix accumulator testbench
// Drives score, query, clear and unused-op items through the request channel
// under several register settings, paces the result channel with random
// stalls, and leaves prediction and comparison to the matrix checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cma_pkg::*;

   // The op encoding leaves one code unused; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Two pipeline stages inside the block; SETTLE_CYCLES covers an item that
   // produces no answer but is still in flight.
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_COUNT   = 12;
   localparam int PHASE_ITEMS   = 125;
   localparam int CYCLE_LIMIT   = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          failures;
   int          answers_due;
   int          answers_checked;
   int          vectors_closed;

   int          sent_by_op [4] = '{default: 0};
   int          csr_writes  = 0;
   int          cycle_count = 0;
   bit          calm        = 1'b0;
   logic        cfg_binary  = 1'b0;
   logic [4:0]  cfg_classes = 5'd2;

   cma_req_if req_if ();
   cma_rsp_if rsp_if ();

   confusion_matrix_accumulator_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   cma_matrix_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .failures        (failures),
      .answers_due     (answers_due),
      .answers_checked (answers_checked),
      .vectors_closed  (vectors_closed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the block hangs on a handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // Mostly no gap, some short ones, a few long ones; none in calm stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(12, 40);
   endfunction

   // Favor the threshold edges and repeated values so ties and the one-half
   // boundary come up often; otherwise any score.
   function automatic logic [SCORE_BITS-1:0] pick_score();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'hFFFF;
         default: return SCORE_BITS'($urandom);
      endcase
   endfunction

   function automatic int classes_in_play();
      if (cfg_binary) return 2;
      if (cfg_classes < 2) return 2;
      if (cfg_classes > MAX_CLASSES) return MAX_CLASSES;
      return cfg_classes;
   endfunction

   // Mostly cells that can hold counts, sometimes anywhere in the store.
   function automatic logic [3:0] pick_class();
      if ($urandom_range(0, 3) != 0) return 4'($urandom_range(0, classes_in_play() - 1));
      return 4'($urandom);
   endfunction

   // Present one item and hold it until accepted. Valid stays high into the
   // next item when no gap follows.
   task automatic send_item(input logic [1:0] op, input logic [SCORE_BITS-1:0] os,
                            input logic [SCORE_BITS-1:0] ts, input logic closes,
                            input logic [3:0] row, input logic [3:0] col);
      int gap;
      req_if.valid        <= 1'b1;
      req_if.op           <= op;
      req_if.out_score    <= os;
      req_if.target_score <= ts;
      req_if.last         <= closes;
      req_if.query_row    <= row;
      req_if.query_col    <= col;
      do @(posedge clock); while (!req_if.ready);
      sent_by_op[op]++;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_query(input logic [3:0] row, input logic [3:0] col);
      send_item(OP_QUERY, SCORE_BITS'($urandom), SCORE_BITS'($urandom), 1'($urandom), row, col);
   endtask

   task automatic send_score(input logic [SCORE_BITS-1:0] os, input logic [SCORE_BITS-1:0] ts,
                             input logic closes);
      send_item(OP_SCORE, os, ts, closes, 4'($urandom), 4'($urandom));
   endtask

   // One register access: setup phase, then access until pready, then idle with
   // psel low, so back-to-back calls never touch psel twice in one step.
   task automatic csr_access(input logic wr, input logic idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (wr) csr_writes++;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait out every awaited answer, then let the pipeline drain.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (answers_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic bm, input logic [4:0] nc);
      settle();
      cfg_binary  = bm;
      cfg_classes = nc;
      csr_access(1'b1, REG_BINARY_MODE, 32'(bm));
      csr_access(1'b1, REG_NUM_CLASSES, 32'(nc));
      csr_access(1'b0, REG_BINARY_MODE, 32'(0));
      csr_access(1'b0, REG_NUM_CLASSES, 32'(0));
   endtask

   // Result side: ready runs of random length broken by random stalls.
   initial begin : result_pacing
      int hold;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int         preset_binary  [8];
      int         preset_classes [8];
      int         n;
      int         len;
      int         r;
      int         eff;
      bit         broken;

      preset_binary  = '{0, 0, 1, 0, 0, 0, 0, 1};
      preset_classes = '{2, 16, 2, 0, 31, 1, 17, 16};

      // Every input known from time zero.
      req_if.valid        <= 1'b0;
      req_if.op           <= OP_SCORE;
      req_if.out_score    <= '0;
      req_if.target_score <= '0;
      req_if.last         <= 1'b0;
      req_if.query_row    <= '0;
      req_if.query_col    <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Registers read back their reset values.
      csr_access(1'b0, REG_BINARY_MODE, 32'(0));
      csr_access(1'b0, REG_NUM_CLASSES, 32'(0));

      // Binary mode: each side of the one-half threshold on both scores,
      // last set on some to show it is ignored, then every cell of the 2x2.
      configure(1'b1, 5'd2);
      send_score(16'h7FFF, 16'h8000, 1'b0);
      send_score(16'h8000, 16'h7FFF, 1'b1);
      send_score(16'hFFFF, 16'hFFFF, 1'b0);
      send_score(16'h0000, 16'h0000, 1'b1);
      for (int q = 0; q < 4; q++) send_query(4'(q / 2), 4'(q % 2));
      send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 4'hF, 4'hF);
      send_query(4'hF, 4'hF);

      // Multiclass with four classes: an all-tie vector must pick class 0.
      configure(1'b0, 5'd4);
      for (int k = 0; k < 4; k++) send_score(16'h1234, 16'h1234, k == 3);
      // Later ties lose, a trailing element past the class count is ignored
      // for the argmax but still closes the vector: expect cell [3][1].
      send_score(16'h0010, 16'h0000, 1'b0);
      send_score(16'h0020, 16'hFFFF, 1'b0);
      send_score(16'h0020, 16'h0001, 1'b0);
      send_score(16'hFFFE, 16'hFFFF, 1'b0);
      send_score(16'hFFFF, 16'hFFFF, 1'b1);
      send_query(4'd3, 4'd1);
      send_query(4'd0, 4'd0);
      send_item(OP_CLEAR, 16'h0000, 16'h0000, 1'b0, 4'h0, 4'h0);
      send_query(4'd3, 4'd1);

      // Random phases: the preset settings first (class count extremes and
      // out-of-range values among them), then random ones.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 8)
            configure(1'(preset_binary[phase]), 5'(preset_classes[phase]));
         else
            configure(1'($urandom), 5'($urandom_range(0, 31)));
         calm = ($urandom_range(0, 3) == 0);
         eff  = classes_in_play();
         n    = 0;
         while (n < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               send_query(pick_class(), pick_class());
               n++;
            end else if (r < 13) begin
               send_item(OP_CLEAR, pick_score(), pick_score(), 1'($urandom),
                         4'($urandom), 4'($urandom));
               n++;
            end else if (r < 14) begin
               send_item(OP_UNUSED, pick_score(), pick_score(), 1'($urandom),
                         4'($urandom), 4'($urandom));
               n++;
            end else if (cfg_binary) begin
               send_score(pick_score(), pick_score(), 1'($urandom));
               n++;
            end else begin
               // Mostly full vectors; some short, some overlong, a few long
               // enough to pin the position counter, and a few left open.
               r = $urandom_range(0, 99);
               if (r < 70) len = eff;
               else if (r < 85) len = $urandom_range(1, eff - 1);
               else if (r < 95) len = eff + $urandom_range(1, 4);
               else len = $urandom_range(32, 36);
               broken = ($urandom_range(0, 19) == 0);
               for (int k = 0; k < len; k++)
                  send_score(pick_score(), pick_score(), (k == len - 1) && !broken);
               n += len;
            end
         end
      end

      calm = 1'b0;
      settle();

      $display("tb: sent %0d score, %0d query, %0d clear and %0d unused-op items, %0d reg writes",
               sent_by_op[OP_SCORE], sent_by_op[OP_QUERY], sent_by_op[OP_CLEAR],
               sent_by_op[OP_UNUSED], csr_writes);
      $display("tb: compared %0d answers, closed %0d multiclass vectors",
               answers_checked, vectors_closed);
      if (failures == 0 && answers_due == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
hdl/cma_pkg.sv
hdl/cma_channels.sv
hdl/cma_tracker.sv
hdl/cma_store.sv
hdl/confusion_matrix_accumulator_unit.sv
bench/cma_matrix_checker.sv
bench/testbench.sv
